>>> hdl/srcu_pkg.sv
// srcu_pkg: shared types and constants of the stripe run centroid unit.
// No dependencies; imported by every module under hdl/.
package srcu_pkg;

    localparam int MAX_ROWS = 2048;
    localparam int MAX_COLS = 4096;

    localparam int PIX_W    = 8;
    localparam int ROW_W    = 12;   // row counter, holds MAX_ROWS itself
    localparam int RIDX_W   = 11;   // row index 0 .. MAX_ROWS-1
    localparam int LEN_W    = 12;
    localparam int COL_W    = 12;
    localparam int WSUM_W   = 19;
    localparam int MSUM_W   = 30;
    localparam int CTR_W    = 19;   // Q8 centroid
    localparam int CNT_W    = 5;    // divider step counter
    localparam int CFG_W    = 12;

    localparam logic [ROW_W-1:0] ROW_LIMIT   = ROW_W'(MAX_ROWS);
    localparam logic [COL_W-1:0] COL_LAST    = COL_W'(MAX_COLS - 1);
    localparam logic [CNT_W-1:0] DIV_STEPS_M1 = CNT_W'(CTR_W - 1);

    // configuration register indexes
    localparam logic [0:0] REG_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_MIN_WIDTH = 1'b1;

    // one finished column, front to back
    typedef struct packed {
        logic              found;
        logic [COL_W-1:0]  column;
        logic [MSUM_W-1:0] moment;
        logic [WSUM_W-1:0] weight;
        logic [LEN_W-1:0]  width;
        logic [RIDX_W-1:0] start;
        logic [LEN_W-1:0]  end_row;
    } col_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } back_state_t;

endpackage

>>> hdl/srcu_front.sv
// srcu_front: pixel intake, run tracking and per-column record build.
// Depends on srcu_pkg; holds the configuration registers.
module srcu_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [srcu_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        pix_accept,
    input  logic [srcu_pkg::PIX_W-1:0]  pix,
    input  logic                        pix_last,
    output logic                        push,
    output srcu_pkg::col_rec_t          rec
);
    import srcu_pkg::*;

    logic [PIX_W-1:0]  thr_reg;
    logic [LEN_W-1:0]  minw_reg;

    logic [ROW_W-1:0]  row_reg,   row_next;
    logic [COL_W-1:0]  col_reg,   col_next;
    logic [RIDX_W-1:0] rstart_reg, rstart_next;
    logic [LEN_W-1:0]  rlen_reg,  rlen_next;
    logic [WSUM_W-1:0] rw_reg,    rw_next;
    logic [MSUM_W-1:0] rm_reg,    rm_next;
    logic [RIDX_W-1:0] bstart_reg, bstart_next;
    logic [LEN_W-1:0]  blen_reg,  blen_next;
    logic [WSUM_W-1:0] bw_reg,    bw_next;
    logic [MSUM_W-1:0] bm_reg,    bm_next;

    logic [RIDX_W-1:0] s_start;
    logic [LEN_W-1:0]  s_len;
    logic [WSUM_W-1:0] s_w;
    logic [MSUM_W-1:0] s_m;
    logic [RIDX_W-1:0] f_start;
    logic [LEN_W-1:0]  f_len;
    logic [WSUM_W-1:0] f_w;
    logic [MSUM_W-1:0] f_m;
    logic [LEN_W-1:0]  minw_eff;
    logic [RIDX_W+PIX_W-1:0] prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= '0;
            minw_reg <= LEN_W'(3);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg  <= cfg_data[PIX_W-1:0];
                REG_MIN_WIDTH: minw_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign prod = row_reg[RIDX_W-1:0] * pix;

    // pixel step: extend or close the current run
    always_comb
    begin
        s_start     = rstart_reg;
        s_len       = rlen_reg;
        s_w         = rw_reg;
        s_m         = rm_reg;
        bstart_next = bstart_reg;
        blen_next   = blen_reg;
        bw_next     = bw_reg;
        bm_next     = bm_reg;
        row_next    = row_reg;
        if (row_reg < ROW_LIMIT)
        begin
            if (pix > thr_reg)
            begin
                if (rlen_reg == '0)
                begin
                    s_start = row_reg[RIDX_W-1:0];
                end
                s_len = rlen_reg + 1'b1;
                s_w   = rw_reg + WSUM_W'(pix);
                s_m   = rm_reg + MSUM_W'(prod);
            end
            else
            begin
                if (rlen_reg > blen_reg)
                begin
                    bstart_next = rstart_reg;
                    blen_next   = rlen_reg;
                    bw_next     = rw_reg;
                    bm_next     = rm_reg;
                end
                s_start = '0;
                s_len   = '0;
                s_w     = '0;
                s_m     = '0;
            end
            row_next = row_reg + 1'b1;
        end
    end

    // column end: final close of the open run
    always_comb
    begin
        if (s_len > blen_next)
        begin
            f_start = s_start;
            f_len   = s_len;
            f_w     = s_w;
            f_m     = s_m;
        end
        else
        begin
            f_start = bstart_next;
            f_len   = blen_next;
            f_w     = bw_next;
            f_m     = bm_next;
        end
    end

    assign minw_eff = (minw_reg == '0) ? LEN_W'(1) : minw_reg;
    assign push     = pix_accept & pix_last;

    always_comb
    begin
        rec.found   = (f_len >= minw_eff);
        rec.column  = col_reg;
        rec.moment  = f_m;
        rec.weight  = f_w;
        rec.width   = f_len;
        rec.start   = f_start;
        rec.end_row = LEN_W'(f_start) + f_len;
    end

    always_comb
    begin
        rstart_next = s_start;
        rlen_next   = s_len;
        rw_next     = s_w;
        rm_next     = s_m;
        col_next    = col_reg;
        if (pix_last)
        begin
            rstart_next = '0;
            rlen_next   = '0;
            rw_next     = '0;
            rm_next     = '0;
            col_next    = (col_reg == COL_LAST) ? '0 : col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg    <= '0;
            col_reg    <= '0;
            rstart_reg <= '0;
            rlen_reg   <= '0;
            rw_reg     <= '0;
            rm_reg     <= '0;
            bstart_reg <= '0;
            blen_reg   <= '0;
            bw_reg     <= '0;
            bm_reg     <= '0;
        end
        else if (pix_accept)
        begin
            rstart_reg <= rstart_next;
            rlen_reg   <= rlen_next;
            rw_reg     <= rw_next;
            rm_reg     <= rm_next;
            col_reg    <= col_next;
            if (pix_last)
            begin
                row_reg    <= '0;
                bstart_reg <= '0;
                blen_reg   <= '0;
                bw_reg     <= '0;
                bm_reg     <= '0;
            end
            else
            begin
                row_reg    <= row_next;
                bstart_reg <= bstart_next;
                blen_reg   <= blen_next;
                bw_reg     <= bw_next;
                bm_reg     <= bm_next;
            end
        end
    end

endmodule

>>> hdl/srcu_fifo.sv
// srcu_fifo: two-entry queue of column records between front and back.
// Depends on srcu_pkg.
module srcu_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  srcu_pkg::col_rec_t    rec_in,
    input  logic                  pop,
    output srcu_pkg::col_rec_t    rec_out,
    output srcu_pkg::fifo_stat_t  stat
);
    import srcu_pkg::*;

    col_rec_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= rec_in;
        end
    end

    assign rec_out    = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> hdl/srcu_back.sv
// srcu_back: radix-2 restoring divider for the Q8 centroid and result register.
// Depends on srcu_pkg; takes records from srcu_fifo.
module srcu_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  srcu_pkg::col_rec_t    rec,
    input  srcu_pkg::fifo_stat_t  stat,
    output logic                  pop,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic                  res_found,
    output logic [srcu_pkg::COL_W-1:0]  res_column,
    output logic [srcu_pkg::CTR_W-1:0]  res_center,
    output logic [srcu_pkg::LEN_W-1:0]  res_width,
    output logic [srcu_pkg::RIDX_W-1:0] res_start,
    output logic [srcu_pkg::LEN_W-1:0]  res_end
);
    import srcu_pkg::*;

    back_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WSUM_W-1:0] rem_reg;     // partial remainder, always below divisor
    logic [CTR_W-1:0]  low_reg;     // dividend bits still to shift in
    logic [CTR_W-1:0]  quo_reg;
    logic [WSUM_W-1:0] div_reg;
    col_rec_t          hold_reg;

    logic [WSUM_W:0]   trial;
    logic              qbit;
    logic [WSUM_W:0]   trial_sub;

    assign trial     = {rem_reg, low_reg[CTR_W-1]};
    assign qbit      = (trial >= {1'b0, div_reg});
    assign trial_sub = trial - {1'b0, div_reg};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!stat.empty)
                begin
                    state_next = rec.found ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: pop       = !stat.empty;
            ST_DIV:  ;
            ST_OUT:  res_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                cnt_reg <= DIV_STEPS_M1;
            end
            else if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // dividend is moment * 256; its top bits start as the remainder
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hold_reg <= rec;
            div_reg  <= rec.weight;
            rem_reg  <= rec.moment[MSUM_W-1:MSUM_W-WSUM_W];
            low_reg  <= {rec.moment[MSUM_W-WSUM_W-1:0], 8'd0};
            quo_reg  <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= qbit ? trial_sub[WSUM_W-1:0] : trial[WSUM_W-1:0];
            low_reg <= {low_reg[CTR_W-2:0], 1'b0};
            quo_reg <= {quo_reg[CTR_W-2:0], qbit};
        end
    end

    assign res_found  = hold_reg.found;
    assign res_column = hold_reg.column;
    assign res_center = quo_reg;
    assign res_width  = hold_reg.width;
    assign res_start  = hold_reg.start;
    assign res_end    = hold_reg.end_row;

endmodule

>>> hdl/stripe_run_centroid_unit.sv
// stripe_run_centroid_unit: top level of the laser stripe centroid block.
// Depends on srcu_pkg, srcu_front, srcu_fifo and srcu_back.
//
// channel   dir  handshake        payload
// s_*       in   tvalid/tready    tdata[7:0] pixel_value, tlast last_in_column
// m_*       out  tvalid/tready    tdata column/center/width/start/end, tuser found
// cfg_*     in   cfg_we           cfg_index selects register, cfg_data value
//
// Flow: pixels transfer one per cycle while s_tready is high; the back end takes
// each column through pop, 19 divider steps and result, then waits for m_tready.
// The divider makes one quotient bit per cycle. A column without a stripe skips it.
// Reset: rst_n clears counters, run state and queue; config returns to 0 and 3.
// Stalls: s_tready drops only while the two-entry column queue is full.
module stripe_run_centroid_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [11:0] cfg_data,
    // pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pixel_value
    input  logic        s_tlast,    // last_in_column
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [11:0] column_index, [30:12] center_row_q8,
                                    // [42:31] stripe_width, [53:43] stripe_start,
                                    // [65:54] stripe_end, [71:66] zero
    output logic        m_tuser     // found
);
    import srcu_pkg::*;

    logic        pix_accept;
    logic        push;
    logic        pop;
    col_rec_t    front_rec;
    col_rec_t    queue_rec;
    fifo_stat_t  q_stat;

    logic              res_found;
    logic [COL_W-1:0]  res_column;
    logic [CTR_W-1:0]  res_center;
    logic [LEN_W-1:0]  res_width;
    logic [RIDX_W-1:0] res_start;
    logic [LEN_W-1:0]  res_end;

    // hold off pixels while the queue cannot take a column end
    assign s_tready   = !q_stat.full;
    assign pix_accept = s_tvalid & s_tready;

    srcu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_accept (pix_accept),
        .pix        (s_tdata),
        .pix_last   (s_tlast),
        .push       (push),
        .rec        (front_rec)
    );

    srcu_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rec_in  (front_rec),
        .pop     (pop),
        .rec_out (queue_rec),
        .stat    (q_stat)
    );

    srcu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec        (queue_rec),
        .stat       (q_stat),
        .pop        (pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_found  (res_found),
        .res_column (res_column),
        .res_center (res_center),
        .res_width  (res_width),
        .res_start  (res_start),
        .res_end    (res_end)
    );

    assign m_tuser = res_found;
    assign m_tdata = {6'd0, res_end, res_start, res_width, res_center, res_column};

`ifndef SYNTHESIS
    // no stripe means no centroid
    a_center_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[30:12] == 19'd0))
        else $error("center nonzero without stripe");

    // empty run carries zero start and end
    a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[42:31] == 12'd0)) |->
        ((m_tdata[53:43] == 11'd0) && (m_tdata[65:54] == 12'd0)))
        else $error("empty run with nonzero bounds");

    // end row is start plus width
    a_end_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[65:54] == ({1'b0, m_tdata[53:43]} + m_tdata[42:31])))
        else $error("stripe end mismatch");

    // queue never takes a column end while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("column queue overflow");
`endif

endmodule
